>>> design/stup_pkg.sv
// Package for the string-to-unsigned parser: word widths, character codes,
// parse phase and digit status types, and the character-to-digit decoder.
// Depends on nothing; imported by string_to_unsigned_parser_top.
`default_nettype none

package stup_pkg;

    localparam int WORD_WIDTH   = 32;
    localparam int OFFSET_WIDTH = 16;
    localparam int BASE_WIDTH   = 6;
    localparam int CHAR_WIDTH   = 8;
    localparam int PROD_WIDTH   = WORD_WIDTH + BASE_WIDTH;
    localparam int OUT_TDATA_WIDTH = ((WORD_WIDTH + OFFSET_WIDTH + 7) / 8) * 8;

    localparam logic [CHAR_WIDTH-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_WIDTH-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_WIDTH-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_WIDTH-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_WIDTH-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_WIDTH-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'h0D;

    localparam logic [BASE_WIDTH-1:0] BASE_DEFAULT = 6'd10;
    localparam logic [BASE_WIDTH-1:0] BASE_OCT     = 6'd8;
    localparam logic [BASE_WIDTH-1:0] BASE_HEX     = 6'd16;
    localparam logic [BASE_WIDTH-1:0] BASE_AUTO    = 6'd0;

    typedef enum logic [5:0] {
        PH_WS     = 6'b000001,
        PH_SIGNED = 6'b000010,
        PH_ZERO   = 6'b000100,
        PH_PREFIX = 6'b001000,
        PH_DIGITS = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_OK   = 2'd1,
        ST_OVF  = 2'd2
    } digit_status_t;

    typedef struct packed {
        logic                  ok;
        logic [BASE_WIDTH-1:0] val;
    } digit_t;

    // Alphanumeric characters map to 0..35; anything else is not a digit.
    function automatic digit_t digit_of(input logic [CHAR_WIDTH-1:0] c);
        digit_t d;
        d.ok  = 1'b1;
        d.val = '0;
        if (c inside {[CH_0:CH_9]})
        begin
            d.val = BASE_WIDTH'(c - CH_0);
        end
        else if (c inside {[CH_LA:CH_LZ]})
        begin
            d.val = BASE_WIDTH'(c - CH_LA + 8'd10);
        end
        else if (c inside {[CH_UA:CH_UZ]})
        begin
            d.val = BASE_WIDTH'(c - CH_UA + 8'd10);
        end
        else
        begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

>>> design/string_to_unsigned_parser_top.sv
// String-to-unsigned parser: one ASCII character per input beat, one
// result beat when the number ends. Uses stup_pkg.
//
// Usage:
//   s_tdata[7:0] carries the character and s_tuser[0] marks the first
//   character of a new string, which clears the parse state. cfg_data sets
//   the number base (0 selects it from the prefix); the base is sampled at
//   the first character that is not white space, and the port is always ready.
//   The result beat on m_tdata holds the value (low word) and the end offset;
//   m_tuser holds overflowed (bit 0) and converted (bit 1).
//   A character is taken into an input register, decoded with a single
//   multiply-add and overflow test against the parse state, and the result
//   is written to an output register: the result beat is loaded when the
//   character that ends the number leaves the input register.
//   One character is accepted per cycle while no result beat is stalled, the
//   rate being set by that one multiply-add stage. When the receiver stalls,
//   the output register holds its beat and one more character waits in the
//   input register; then s_tready falls until the result beat is taken.
//   Reset clears the parse state to white space skipping, the base to 0 and
//   both registers to empty; characters after reset parse as a new string.
`default_nettype none

module string_to_unsigned_parser_top
    import stup_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [BASE_WIDTH-1:0]      cfg_data,      // base_select
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [CHAR_WIDTH-1:0]      s_tdata,       // char_in
    input  wire logic [0:0]                 s_tuser,       // start_req
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [OUT_TDATA_WIDTH-1:0]      m_tdata,       // value, end_offset
    output logic [1:0]                      m_tuser        // overflowed, converted
);

    logic [BASE_WIDTH-1:0]   base_select_reg;

    logic                    in_valid_reg;
    logic                    in_valid_next;
    logic [CHAR_WIDTH-1:0]   char_reg;
    logic                    start_reg;

    phase_t                  phase_reg, phase_next;
    logic [WORD_WIDTH-1:0]   acc_reg, acc_next;
    logic                    minus_reg, minus_next;
    digit_status_t           status_reg, status_next;
    logic [BASE_WIDTH-1:0]   base_reg, base_next;
    logic [OFFSET_WIDTH-1:0] pos_reg, pos_next;

    logic                    out_valid_reg, out_valid_next;
    logic [WORD_WIDTH-1:0]   value_reg, value_next;
    logic [OFFSET_WIDTH-1:0] offset_reg, offset_next;
    logic                    ovf_reg, ovf_next;
    logic                    conv_reg, conv_next;

    logic                    advance;
    logic                    step;
    logic                    produce;
    logic                    take_first;
    logic                    take_digit;
    digit_t                  dig;
    logic [BASE_WIDTH-1:0]   mult_base;
    logic [PROD_WIDTH-1:0]   prod;
    phase_t                  ph_cur;
    logic [OFFSET_WIDTH-1:0] pos_cur;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_select_reg <= '0;
        end
        else if (cfg_valid)
        begin
            base_select_reg <= cfg_data;
        end
    end

    // The stage advances whenever the output register is free or being taken.
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next = (s_tvalid && s_tready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            char_reg  <= s_tdata;
            start_reg <= s_tuser[0];
        end
    end

    always_comb
    begin
        ph_cur      = start_reg ? PH_WS : phase_reg;
        pos_cur     = start_reg ? '0 : pos_reg;
        phase_next  = ph_cur;
        acc_next    = start_reg ? '0 : acc_reg;
        minus_next  = start_reg ? 1'b0 : minus_reg;
        status_next = start_reg ? ST_NONE : status_reg;
        base_next   = start_reg ? BASE_AUTO : base_reg;
        pos_next    = pos_cur;
        take_first  = 1'b0;
        take_digit  = 1'b0;
        produce     = 1'b0;
        value_next  = '0;
        offset_next = '0;
        ovf_next    = 1'b0;
        conv_next   = 1'b0;
        dig         = digit_of(char_reg);
        mult_base   = BASE_DEFAULT;
        prod        = '0;

        case (ph_cur)
            PH_WS:
            begin
                if (!(char_reg inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_VT, CH_FF}))
                begin
                    base_next = base_select_reg;
                    if (char_reg == CH_MINUS)
                    begin
                        minus_next = 1'b1;
                        phase_next = PH_SIGNED;
                    end
                    else if (char_reg == CH_PLUS)
                    begin
                        phase_next = PH_SIGNED;
                    end
                    else
                    begin
                        take_first = 1'b1;
                    end
                end
            end
            PH_SIGNED:
            begin
                take_first = 1'b1;
            end
            PH_ZERO:
            begin
                if (char_reg == CH_LX || char_reg == CH_UX)
                begin
                    base_next  = BASE_HEX;
                    phase_next = PH_PREFIX;
                end
                else
                begin
                    // The leading zero counts as a digit from here on.
                    if (base_next == BASE_AUTO)
                    begin
                        base_next = BASE_OCT;
                    end
                    status_next = ST_OK;
                    acc_next    = '0;
                    take_digit  = 1'b1;
                end
            end
            PH_PREFIX, PH_DIGITS:
            begin
                take_digit = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (take_first)
        begin
            if ((base_next == BASE_AUTO || base_next == BASE_HEX) && char_reg == CH_0)
            begin
                phase_next = PH_ZERO;
            end
            else
            begin
                if (base_next == BASE_AUTO)
                begin
                    base_next = BASE_DEFAULT;
                end
                take_digit = 1'b1;
            end
        end

        if (take_digit)
        begin
            mult_base = (base_next == BASE_AUTO) ? BASE_DEFAULT : base_next;
            if (!dig.ok || dig.val >= mult_base)
            begin
                produce     = 1'b1;
                phase_next  = PH_DONE;
                value_next  = (status_next == ST_OK && minus_next)
                              ? (WORD_WIDTH'(0) - acc_next) : acc_next;
                offset_next = (status_next != ST_NONE) ? pos_cur : '0;
                ovf_next    = (status_next == ST_OVF);
                conv_next   = (status_next != ST_NONE);
            end
            else
            begin
                phase_next = PH_DIGITS;
                if (status_next != ST_OVF)
                begin
                    prod = PROD_WIDTH'(acc_next) * PROD_WIDTH'(mult_base)
                           + PROD_WIDTH'(dig.val);
                    if (|prod[PROD_WIDTH-1:WORD_WIDTH])
                    begin
                        status_next = ST_OVF;
                        acc_next    = '1;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        acc_next    = prod[WORD_WIDTH-1:0];
                    end
                end
            end
        end

        // Characters after the end are ignored and do not move the position.
        if (ph_cur != PH_DONE && pos_cur != '1)
        begin
            pos_next = pos_cur + OFFSET_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WS;
            acc_reg    <= '0;
            minus_reg  <= 1'b0;
            status_reg <= ST_NONE;
            base_reg   <= '0;
            pos_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            minus_reg  <= minus_next;
            status_reg <= status_next;
            base_reg   <= base_next;
            pos_reg    <= pos_next;
        end
    end

    assign out_valid_next = advance ? (in_valid_reg && produce) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && produce)
        begin
            value_reg  <= value_next;
            offset_reg <= offset_next;
            ovf_reg    <= ovf_next;
            conv_reg   <= conv_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_WIDTH'({offset_reg, value_reg});
    assign m_tuser  = {conv_reg, ovf_reg};

    // A beat without conversion carries zero value and zero offset.
    a_no_conv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !conv_reg) |-> (value_reg == '0 && offset_reg == '0 && !ovf_reg))
        else $error("result without conversion is not all zero");

    // A saturated result is the all-ones word and counts as converted.
    a_ovf_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ovf_reg) |-> (value_reg == '1 && conv_reg))
        else $error("overflowed result is not saturated");

    // The input side only backs up while a result beat is stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (out_valid_reg && !m_tready && in_valid_reg))
        else $error("input stalled without a stalled result");

    // A new result beat needs a character in the input register in the cycle before.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result beat without an input character");

endmodule

`default_nettype wire
